@@ design/ktid_pkg.sv @@
// Shared types and codes for the keyed record table.
// Used by the table top level, its record store and its checker.
package ktid_pkg;

	// status codes of a result beat
	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_DUPLICATE = 3'd1;
	localparam logic [2:0] ST_DELETED   = 3'd2;
	localparam logic [2:0] ST_NOTFOUND  = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	// action codes of a request beat
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_DELETE = 1'b1;

	typedef struct packed {
		logic               action;
		logic signed [31:0] entry_key;
		logic        [63:0] entry_payload;
	} in_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] entry_count;
	} out_t;

	// one stored record
	typedef struct packed {
		logic [31:0] key;
		logic [63:0] payload;
	} rec_t;

endpackage

@@ design/ktid_store.sv @@
// Record store of the keyed table: key and payload memories side by side.
// One write port, one read port with registered data. Depends on ktid_pkg.
module ktid_store import ktid_pkg::*; #(
	parameter int TABLE_DEPTH = 128,
	parameter int AW          = $clog2(TABLE_DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  rec_t          wdata,
	input  logic [AW-1:0] raddr,
	output rec_t          rdata
);

	logic [31:0] key_mem [TABLE_DEPTH];
	logic [63:0] pay_mem [TABLE_DEPTH];

	// registered read, old data on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[waddr] <= wdata.key;
			pay_mem[waddr] <= wdata.payload;
		end
		rdata.key     <= key_mem[raddr];
		rdata.payload <= pay_mem[raddr];
	end

endmodule

@@ design/keyed_table_insert_delete.sv @@
// Keyed record table: dense list of unique keys with payload words, in insertion order.
// Each request first scans the stored keys; a delete that hits then compacts the records
// behind the hit one place down to close the gap.
// One request at a time, next accept at the edge that ends the result beat; the single
// read port of the record store sets the pace. Reset clears the count, not the records.
// The result strobe done lasts one cycle; the receiver cannot stall.
module keyed_table_insert_delete import ktid_pkg::*; #(
	parameter int TABLE_DEPTH = 128
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  in_t  item,
	output logic done,
	output out_t result
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_SHIFT = 2'd2;

	logic [1:0]    state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_idx_q;
	logic          vld_s1;
	logic [AW-1:0] idx_s1;
	in_t           req_q;
	logic          done_q;
	out_t          result_q;

	logic          we;
	logic [AW-1:0] waddr;
	rec_t          wdata;
	rec_t          rdata;
	logic          issue;
	logic          hit;
	logic          drained;
	logic [31:0]   cnt_inc_ext;
	logic [31:0]   cnt_dec_ext;
	logic [31:0]   cnt_cur_ext;

	ktid_store #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.AW         (AW)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(rd_idx_q[AW-1:0]),
		.rdata(rdata)
	);

	// scan and shift status
	assign issue   = (state_q != S_IDLE) && (rd_idx_q < count_q);
	assign hit     = (state_q == S_SCAN) && vld_s1 && (rdata.key == req_q.entry_key);
	assign drained = !vld_s1 && (rd_idx_q >= count_q);

	assign cnt_cur_ext = 32'(count_q);
	assign cnt_inc_ext = cnt_cur_ext + 32'd1;
	assign cnt_dec_ext = cnt_cur_ext - 32'd1;

	// store write port: append on insert, move a record down during shift
	always_comb begin
		we    = 1'b0;
		waddr = count_q[AW-1:0];
		wdata = '{key: req_q.entry_key, payload: req_q.entry_payload};
		case (state_q)
			S_SCAN: begin
				if (!hit && drained && req_q.action == ACT_INSERT &&
				    count_q != CW'(TABLE_DEPTH)) begin
					we = 1'b1;
				end
			end
			S_SHIFT: begin
				if (vld_s1) begin
					we    = 1'b1;
					waddr = idx_s1 - AW'(1);
					wdata = rdata;
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// track read pipeline: one read in flight tag per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (state_q == S_IDLE || hit) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q[AW-1:0];
	end

	// sequencer: accept, scan, compact, report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			rd_idx_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						rd_idx_q <= '0;
						state_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (issue) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
					if (hit) begin
						if (req_q.action == ACT_INSERT) begin
							done_q   <= 1'b1;
							state_q  <= S_IDLE;
						end else begin
							rd_idx_q <= CW'(idx_s1) + CW'(1);
							state_q  <= S_SHIFT;
						end
					end else if (drained) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
						if (req_q.action == ACT_INSERT && count_q != CW'(TABLE_DEPTH)) begin
							count_q <= count_q + CW'(1);
						end
					end
				end
				S_SHIFT: begin
					if (issue) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
					if (drained) begin
						count_q <= count_q - CW'(1);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// hold the request beat
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q <= item;
		end
	end

	// build the result beat
	always_ff @(posedge clk) begin
		case (state_q)
			S_SCAN: begin
				if (hit) begin
					result_q.status      <= ST_DUPLICATE;
					result_q.entry_count <= cnt_cur_ext[7:0];
				end else if (req_q.action == ACT_DELETE) begin
					result_q.status      <= ST_NOTFOUND;
					result_q.entry_count <= cnt_cur_ext[7:0];
				end else if (count_q == CW'(TABLE_DEPTH)) begin
					result_q.status      <= ST_FULL;
					result_q.entry_count <= cnt_cur_ext[7:0];
				end else begin
					result_q.status      <= ST_INSERTED;
					result_q.entry_count <= cnt_inc_ext[7:0];
				end
			end
			S_SHIFT: begin
				result_q.status      <= ST_DELETED;
				result_q.entry_count <= cnt_dec_ext[7:0];
			end
			default: begin
				result_q <= result_q;
			end
		endcase
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

@@ design/ktid_checker.sv @@
// Port-level checks for the keyed record table, bound to its top level.
// Depends on ktid_pkg and keyed_table_insert_delete.
module ktid_assertions import ktid_pkg::*; #(
	parameter int TABLE_DEPTH = 128
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input out_t result
);

	logic [31:0] depth_ext;
	assign depth_ext = 32'(TABLE_DEPTH);

	// an accepted beat makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted beat did not raise busy");

	// a result beat ends a busy period
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without a request in work");

	// result beats never come back to back
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beats back to back");

	// status codes stay in range
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status <= ST_FULL))
		else $error("undefined status code");

	// a full rejection reports a full table
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_FULL |-> result.entry_count == depth_ext[7:0])
		else $error("full status with wrong count");

endmodule

bind keyed_table_insert_delete ktid_assertions #(
	.TABLE_DEPTH(TABLE_DEPTH)
) u_ktid_assertions (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.result(result)
);
